// ----- hdl/packed_saturating_counter_array_core_assert.svh -----
// Assertion macros shared by the RTL files.
`ifndef PACKED_SATURATING_COUNTER_ARRAY_CORE_ASSERT_SVH
`define PACKED_SATURATING_COUNTER_ARRAY_CORE_ASSERT_SVH

`ifndef SYNTH

`define PSCA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

`define PSCA_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`else

`define PSCA_ASSERT(label, clk, rst, prop)

`define PSCA_ASSERT_NORST(label, clk, prop)

`endif

`endif

// ----- hdl/psca_pkg.sv -----
`default_nettype none

package psca_pkg;

   localparam int WORD_BITS = 8;
   localparam int MODE_W    = 2;
   localparam int NUMBER_W  = 10;
   localparam int COUNT_W   = 8;
   localparam int MAXNUM_W  = 10;
   localparam int KW_W      = 4;
   localparam int POS_W     = 13;
   localparam int IDX_W     = 10;
   localparam int WIN_W     = 2 * WORD_BITS;
   localparam int SH_W      = 5;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [MAXNUM_W-1:0] MAX_NUMBER_RST    = 10'd1023;
   localparam logic [KW_W-1:0]     COUNTER_WIDTH_RST = 4'd2;
   localparam logic [KW_W-1:0]     K_MIN             = 4'd1;
   localparam logic [KW_W-1:0]     K_MAX             = 4'd8;

   typedef enum logic [MODE_W-1:0] {
      MODE_INC  = 2'd0,
      MODE_READ = 2'd1,
      MODE_CPL  = 2'd2,
      MODE_RSVD = 2'd3
   } mode_type;

   typedef enum logic {
      REG_MAX_NUMBER    = 1'b0,
      REG_COUNTER_WIDTH = 1'b1
   } reg_type;

   typedef struct packed {
      logic [MAXNUM_W-1:0] max_number;
      logic [KW_W-1:0]     counter_width;
   } cfg_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic slot_free;
   } sts_type;

   function automatic logic [KW_W-1:0] eff_width(input logic [KW_W-1:0] w);
      logic [KW_W-1:0] k;
      if (w < K_MIN) begin
         k = K_MIN;
      end else if (w > K_MAX) begin
         k = K_MAX;
      end else begin
         k = w;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/psca_if.sv -----
`default_nettype none

interface psca_req_if;
   logic                          valid;
   logic                          ready;
   logic [psca_pkg::MODE_W-1:0]   mode;
   logic [psca_pkg::NUMBER_W-1:0] number;
   modport source (output valid, mode, number, input ready);
   modport sink   (input valid, mode, number, output ready);
endinterface

interface psca_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [psca_pkg::COUNT_W-1:0] count;
   logic                         in_range;
   modport source (output valid, count, in_range, input ready);
   modport sink   (input valid, count, in_range, output ready);
endinterface

`default_nettype wire

// ----- hdl/psca_csr.sv -----
`default_nettype none

module psca_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [psca_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [psca_pkg::DATA_W-1:0]   pwdata,
   output      logic [psca_pkg::DATA_W-1:0]   prdata,
   output      logic                          pready,
   output      psca_pkg::cfg_type             cfg
);

   psca_pkg::cfg_type cfg_ff;
   psca_pkg::cfg_type cfg_in;
   psca_pkg::reg_type reg_sel;

   assign reg_sel = psca_pkg::reg_type'(paddr[2]);
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (reg_sel)
            psca_pkg::REG_MAX_NUMBER: begin
               cfg_in.max_number = pwdata[psca_pkg::MAXNUM_W-1:0];
            end
            psca_pkg::REG_COUNTER_WIDTH: begin
               cfg_in.counter_width = pwdata[psca_pkg::KW_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         psca_pkg::REG_MAX_NUMBER: begin
            prdata = psca_pkg::DATA_W'(cfg_ff.max_number);
         end
         psca_pkg::REG_COUNTER_WIDTH: begin
            prdata = psca_pkg::DATA_W'(cfg_ff.counter_width);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_number    <= psca_pkg::MAX_NUMBER_RST;
         cfg_ff.counter_width <= psca_pkg::COUNTER_WIDTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/psca_ctrl.sv -----
`default_nettype none
`include "packed_saturating_counter_array_core_assert.svh"

module psca_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire psca_pkg::sts_type sts,
   output      psca_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (sts.slot_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `PSCA_ASSERT(a_accept_then_update, clock, reset, (req_valid && req_ready) |=> (state_ff == ST_UPDATE))
   `PSCA_ASSERT(a_clear_only_once, clock, reset, (state_ff != ST_CLEAR) |=> (state_ff != ST_CLEAR))
   `PSCA_ASSERT(a_update_follows_load, clock, reset, cmd.update |-> ($past(cmd.load) || $past(state_ff == ST_UPDATE)))

endmodule

`default_nettype wire

// ----- hdl/psca_dp.sv -----
`default_nettype none
`include "packed_saturating_counter_array_core_assert.svh"

module psca_dp #(
   parameter int MAX_NUMBERS = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire psca_pkg::cmd_type             cmd,
   output      psca_pkg::sts_type             sts,
   input  wire psca_pkg::cfg_type             cfg,
   input  wire logic [psca_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [psca_pkg::NUMBER_W-1:0] req_number,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [psca_pkg::COUNT_W-1:0]  rsp_count,
   output      logic                          rsp_in_range
);

   localparam int BANK_DEPTH = (MAX_NUMBERS + 1) / 2;
   localparam int BW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int XW         = (BW > psca_pkg::IDX_W) ? BW : psca_pkg::IDX_W;
   localparam int RW         = 17;
   localparam int WB         = psca_pkg::WORD_BITS;

   logic [WB-1:0] even_mem [0:(1<<BW)-1];
   logic [WB-1:0] odd_mem  [0:(1<<BW)-1];

   logic [psca_pkg::KW_W-1:0]   k_c;
   logic [psca_pkg::POS_W-1:0]  pos_c;
   logic [psca_pkg::IDX_W-1:0]  idx_c;
   logic [psca_pkg::IDX_W-1:0]  ev_num_c;
   logic [XW-1:0]               ev_wide_c;
   logic [XW-1:0]               od_wide_c;
   logic [BW-1:0]               ev_addr_c;
   logic [BW-1:0]               od_addr_c;
   logic                        in_range_c;
   logic                        straddle_c;

   logic [psca_pkg::KW_W-1:0]   k_ff;
   logic [2:0]                  off_ff;
   psca_pkg::mode_type          mode_ff;
   logic                        in_range_ff;
   logic                        odd_first_ff;
   logic                        straddle_ff;
   logic [BW-1:0]               ev_addr_ff;
   logic [BW-1:0]               od_addr_ff;
   logic [WB-1:0]               rd_even_ff;
   logic [WB-1:0]               rd_odd_ff;
   logic [BW-1:0]               clr_cnt_ff;
   logic [BW-1:0]               clr_cnt_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [psca_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                        rsp_in_range_ff;

   logic [psca_pkg::WIN_W-1:0]  window;
   logic [psca_pkg::WIN_W-1:0]  new_win;
   logic [psca_pkg::SH_W-1:0]   sh;
   logic [WB-1:0]               full;
   logic [WB-1:0]               cur;
   logic [WB-1:0]               nv;
   logic                        write_en;
   logic                        even_we;
   logic                        odd_we;
   logic [BW-1:0]               even_wa;
   logic [BW-1:0]               odd_wa;
   logic [WB-1:0]               even_wd;
   logic [WB-1:0]               odd_wd;

   always_comb begin
      k_c        = psca_pkg::eff_width(cfg.counter_width);
      pos_c      = {3'b000, req_number} * {9'b0_0000_0000, k_c};
      idx_c      = pos_c[psca_pkg::POS_W-1:3];
      ev_num_c   = psca_pkg::IDX_W'(({1'b0, idx_c} + 11'd1) >> 1);
      ev_wide_c  = XW'(ev_num_c);
      od_wide_c  = XW'(idx_c[psca_pkg::IDX_W-1:1]);
      ev_addr_c  = ev_wide_c[BW-1:0];
      od_addr_c  = od_wide_c[BW-1:0];
      in_range_c = (req_number <= cfg.max_number) &&
                   ({7'b000_0000, req_number} < RW'(MAX_NUMBERS));
      straddle_c = ({1'b0, pos_c[2:0]} + k_c) > psca_pkg::K_MAX;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         k_ff         <= k_c;
         off_ff       <= pos_c[2:0];
         mode_ff      <= psca_pkg::mode_type'(req_mode);
         in_range_ff  <= in_range_c;
         odd_first_ff <= idx_c[0];
         straddle_ff  <= straddle_c;
         ev_addr_ff   <= ev_addr_c;
         od_addr_ff   <= od_addr_c;
      end
   end

   always_comb begin
      window = odd_first_ff ? {rd_odd_ff, rd_even_ff} : {rd_even_ff, rd_odd_ff};
      sh     = 5'd16 - {2'b00, off_ff} - {1'b0, k_ff};
      full   = WB'((9'd1 << k_ff) - 9'd1);
      cur    = WB'(window >> sh) & full;
      case (mode_ff)
         psca_pkg::MODE_INC: begin
            nv = (cur == full) ? cur : cur + 8'd1;
         end
         psca_pkg::MODE_CPL: begin
            nv = ~cur & full;
         end
         default: begin
            nv = cur;
         end
      endcase
      new_win  = (window & ~({8'h00, full} << sh)) | ({8'h00, nv} << sh);
      write_en = cmd.update && in_range_ff &&
                 ((mode_ff == psca_pkg::MODE_INC) || (mode_ff == psca_pkg::MODE_CPL));

      even_we = cmd.clear || (write_en && (!odd_first_ff || straddle_ff));
      odd_we  = cmd.clear || (write_en && (odd_first_ff || straddle_ff));
      even_wa = cmd.clear ? clr_cnt_ff : ev_addr_ff;
      odd_wa  = cmd.clear ? clr_cnt_ff : od_addr_ff;
      if (cmd.clear) begin
         even_wd = '0;
         odd_wd  = '0;
      end else if (odd_first_ff) begin
         odd_wd  = new_win[psca_pkg::WIN_W-1:WB];
         even_wd = new_win[WB-1:0];
      end else begin
         even_wd = new_win[psca_pkg::WIN_W-1:WB];
         odd_wd  = new_win[WB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (even_we) begin
         even_mem[even_wa] <= even_wd;
      end
      if (cmd.load) begin
         rd_even_ff <= even_mem[ev_addr_c];
      end
   end

   always_ff @(posedge clock) begin
      if (odd_we) begin
         odd_mem[odd_wa] <= odd_wd;
      end
      if (cmd.load) begin
         rd_odd_ff <= odd_mem[od_addr_c];
      end
   end

   always_comb begin
      clr_cnt_in = cmd.clear ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_count_ff    <= in_range_ff ? nv : '0;
         rsp_in_range_ff <= in_range_ff;
      end
   end

   assign sts.clear_last = (clr_cnt_ff == '1);
   assign sts.slot_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_in_range   = rsp_in_range_ff;

   `PSCA_ASSERT(a_valid_from_update, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd.update))
   `PSCA_ASSERT(a_out_of_range_zero, clock, reset, (cmd.update && !in_range_ff) |=> (rsp_count_ff == '0))
   `PSCA_ASSERT(a_no_result_in_clear, clock, reset, cmd.clear |=> !rsp_valid_ff)

endmodule

`default_nettype wire

// ----- hdl/packed_saturating_counter_array_core.sv -----
// Packed saturating counter array: one counter of 1 to 8 bits for each number up to
// max_number (and below MAX_NUMBERS), packed MSB-first into a byte store held as an even
// bank and an odd bank, so both bytes that a counter may touch are read together. Each
// request increments (saturating), reads or complements the addressed counter (the
// reserved mode only reads), and the response carries the value after the operation,
// or zero with in_range low for a number out of range. The idle state accepts an item
// and reads both banks into registers; the update state then modifies, writes back and
// loads the response register, and waits while a previous response has not been taken.
// After reset the block clears every entry of both banks, one entry of each bank per
// cycle, before it accepts a request; register writes are taken throughout.
`default_nettype none

module packed_saturating_counter_array_core #(
   parameter int MAX_NUMBERS = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   psca_req_if.sink                         req_ch,
   psca_rsp_if.source                       rsp_ch,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [psca_pkg::ADDR_W-1:0] paddr,
   input  wire logic [psca_pkg::DATA_W-1:0] pwdata,
   output      logic [psca_pkg::DATA_W-1:0] prdata,
   output      logic                        pready
);

   psca_pkg::cfg_type cfg;
   psca_pkg::cmd_type cmd;
   psca_pkg::sts_type sts;

   psca_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   psca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   psca_dp #(
      .MAX_NUMBERS (MAX_NUMBERS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .cfg          (cfg),
      .req_mode     (req_ch.mode),
      .req_number   (req_ch.number),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_count    (rsp_ch.count),
      .rsp_in_range (rsp_ch.in_range)
   );

endmodule

`default_nettype wire

// ----- verif/psca_count_check_pkg.sv -----
package psca_count_check_pkg;

   import psca_pkg::*;

   localparam int STORE_BITS = 1024 * WORD_BITS;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               in_range;
   } count_result_type;

   class count_scoreboard;
      bit                  store_bits [STORE_BITS];
      logic [MAXNUM_W-1:0] max_number;
      logic [KW_W-1:0]     counter_width;
      count_result_type    expected_counts [$];
      int                  errors;

      function new();
         max_number    = MAX_NUMBER_RST;
         counter_width = COUNTER_WIDTH_RST;
         errors        = 0;
      endfunction

      function void write_register(reg_type r, logic [DATA_W-1:0] value);
         if (r == REG_MAX_NUMBER) begin
            max_number = value[MAXNUM_W-1:0];
         end else begin
            counter_width = value[KW_W-1:0];
         end
      endfunction

      function logic [DATA_W-1:0] register_value(reg_type r);
         if (r == REG_MAX_NUMBER) begin
            return DATA_W'(max_number);
         end
         return DATA_W'(counter_width);
      endfunction

      // Widths outside 1..8 are clamped to the nearest legal width.
      function int bits_per_counter();
         if (counter_width == 0) begin
            return 1;
         end else if (counter_width > 8) begin
            return 8;
         end
         return int'(counter_width);
      endfunction

      function void note_request(mode_type mode, logic [NUMBER_W-1:0] number);
         int               k;
         int               full;
         int               first;
         int               value;
         count_result_type r;
         k    = bits_per_counter();
         full = (1 << k) - 1;
         r    = '0;
         if (number <= max_number) begin
            first = int'(number) * k;
            value = 0;
            for (int i = 0; i < k; i++) begin
               value = (value << 1) | int'(store_bits[first + i]);
            end
            if (mode == MODE_INC && value < full) begin
               value = value + 1;
            end else if (mode == MODE_CPL) begin
               value = ~value & full;
            end
            if (mode == MODE_INC || mode == MODE_CPL) begin
               for (int i = 0; i < k; i++) begin
                  store_bits[first + i] = value[k - 1 - i];
               end
            end
            r.count    = value[COUNT_W-1:0];
            r.in_range = 1'b1;
         end
         expected_counts.push_back(r);
      endfunction

      function void check_response(logic [COUNT_W-1:0] count, logic in_range);
         count_result_type e;
         if (expected_counts.size() == 0) begin
            $error("Response transfer arrived with no request outstanding.");
            errors++;
            return;
         end
         e = expected_counts.pop_front();
         if (count !== e.count) begin
            $error("count mismatch: expected %0d, actual %0d", e.count, count);
            errors++;
         end
         if (in_range !== e.in_range) begin
            $error("in_range mismatch: expected %0d, actual %0d", e.in_range, in_range);
            errors++;
         end
      endfunction

      function int pending();
         return expected_counts.size();
      endfunction
   endclass

endpackage

// ----- verif/tb_packed_saturating_counter_array_core.sv -----
module tb_packed_saturating_counter_array_core;

   timeunit 1ns;
   timeprecision 1ps;

   import psca_pkg::*;
   import psca_count_check_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 110;

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   int                  cycles       = 0;
   int                  tx_idle_pct  = 0;
   int                  rx_stall_pct = 0;
   count_scoreboard     sb           = new();

   psca_req_if req_ch ();
   psca_rsp_if rsp_ch ();

   packed_saturating_counter_array_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_response(rsp_ch.count, rsp_ch.in_range);
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(99) >= rx_stall_pct);
   end

   task automatic send_item(mode_type m, logic [NUMBER_W-1:0] n);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid  = 1'b1;
      req_ch.mode   = m;
      req_ch.number = n;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(m, n);
      @(negedge clock);
   endtask

   task automatic wait_for_idle();
      req_ch.valid = 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_access(reg_type r, logic write, logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] read_data;
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = write;
      paddr   = ADDR_W'({r, 2'b00});
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      read_data = prdata;
      if (write) begin
         sb.write_register(r, value);
      end else if (read_data !== sb.register_value(r)) begin
         $error("%s mismatch: expected %0d, actual %0d", r.name(),
                sb.register_value(r), read_data);
         sb.errors++;
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic configure(int max_n, int width);
      csr_access(REG_MAX_NUMBER, 1'b1, DATA_W'(max_n));
      csr_access(REG_COUNTER_WIDTH, 1'b1, DATA_W'(width));
      csr_access(REG_MAX_NUMBER, 1'b0, '0);
      csr_access(REG_COUNTER_WIDTH, 1'b0, '0);
   endtask

   function automatic mode_type pick_mode();
      int sel;
      sel = $urandom_range(99);
      if (sel < 55) begin
         return MODE_INC;
      end else if (sel < 75) begin
         return MODE_READ;
      end else if (sel < 93) begin
         return MODE_CPL;
      end
      return MODE_RSVD;
   endfunction

   function automatic logic [NUMBER_W-1:0] pick_number(int max_n, int base);
      int sel;
      int n;
      sel = $urandom_range(99);
      if (sel < 70) begin
         n = base + $urandom_range(15);
         if (n > max_n) begin
            n = $urandom_range(max_n);
         end
      end else if (sel < 88) begin
         n = $urandom_range(max_n);
      end else begin
         n = $urandom_range(1023);
      end
      return NUMBER_W'(n);
   endfunction

   initial begin
      int phase_max   [PHASES];
      int phase_width [PHASES];
      int tx_table    [4];
      int rx_table    [4];
      int max_n;
      int width;
      int base;

      phase_max   = '{1023, 1023, 0, 511, 1023, 700, -1, 1023, -1, 300};
      phase_width = '{1, 8, 3, 0, 15, 5, -1, 7, 9, 4};
      tx_table    = '{0, 67, 0, 23};
      rx_table    = '{0, 0, 67, 23};

      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.mode   = MODE_INC;
      req_ch.number = '0;
      rsp_ch.ready  = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset layout: two-bit counters, every number in range.
      send_item(MODE_READ, 10'd0);
      send_item(MODE_READ, 10'd1023);
      repeat (4) send_item(MODE_INC, 10'd0);
      send_item(MODE_CPL, 10'd0);
      send_item(MODE_CPL, 10'd0);
      send_item(MODE_INC, 10'd1);
      send_item(MODE_RSVD, 10'd1);
      send_item(MODE_INC, 10'd1023);
      send_item(MODE_CPL, 10'd1023);
      wait_for_idle();

      // A single number in range, with the old bits seen as one byte-wide counter.
      configure(0, 8);
      send_item(MODE_INC, 10'd0);
      send_item(MODE_READ, 10'd1);
      send_item(MODE_CPL, 10'd1023);
      send_item(MODE_INC, 10'd512);
      send_item(MODE_CPL, 10'd0);
      send_item(MODE_READ, 10'd0);
      wait_for_idle();

      for (int p = 0; p < PHASES; p++) begin
         max_n = (phase_max[p] < 0) ? int'($urandom_range(1023)) : phase_max[p];
         width = (phase_width[p] < 0) ? int'($urandom_range(1, 8)) : phase_width[p];
         configure(max_n, width);
         tx_idle_pct  = tx_table[p % 4];
         rx_stall_pct = rx_table[p % 4];
         base = $urandom_range(max_n);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 30 == 29) begin
               base = $urandom_range(max_n);
            end
            if (i == PHASE_ITEMS / 2) begin
               wait_for_idle();
            end
            send_item(pick_mode(), pick_number(max_n, base));
         end
         wait_for_idle();
      end

      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      wait_for_idle();
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- packed_saturating_counter_array_core.f -----
+incdir+hdl
hdl/psca_pkg.sv
hdl/psca_if.sv
hdl/psca_csr.sv
hdl/psca_ctrl.sv
hdl/psca_dp.sv
hdl/packed_saturating_counter_array_core.sv
verif/psca_count_check_pkg.sv
verif/tb_packed_saturating_counter_array_core.sv
